@@ hdl/afsu_pkg.sv @@
// Shared types and codes of the accumulator frame/stack unit.
// Depends on nothing; the top level, front end and back end import it.
package afsu_pkg;

    localparam logic [4:0] CMD_CONST  = 5'd0;
    localparam logic [4:0] CMD_ADD    = 5'd1;
    localparam logic [4:0] CMD_SUB    = 5'd2;
    localparam logic [4:0] CMD_REVSUB = 5'd3;
    localparam logic [4:0] CMD_MUL    = 5'd4;
    localparam logic [4:0] CMD_NEG    = 5'd5;
    localparam logic [4:0] CMD_EQ     = 5'd6;
    localparam logic [4:0] CMD_NE     = 5'd7;
    localparam logic [4:0] CMD_LT     = 5'd8;
    localparam logic [4:0] CMD_LE     = 5'd9;
    localparam logic [4:0] CMD_GT     = 5'd10;
    localparam logic [4:0] CMD_GE     = 5'd11;
    localparam logic [4:0] CMD_PADD   = 5'd12;
    localparam logic [4:0] CMD_PSUB   = 5'd13;
    localparam logic [4:0] CMD_PMUL   = 5'd14;
    localparam logic [4:0] CMD_PEQ    = 5'd15;
    localparam logic [4:0] CMD_PNE    = 5'd16;
    localparam logic [4:0] CMD_PLT    = 5'd17;
    localparam logic [4:0] CMD_PLE    = 5'd18;
    localparam logic [4:0] CMD_PGT    = 5'd19;
    localparam logic [4:0] CMD_PGE    = 5'd20;
    localparam logic [4:0] CMD_LOAD   = 5'd21;
    localparam logic [4:0] CMD_STORE  = 5'd22;
    localparam logic [4:0] CMD_PUSH   = 5'd23;
    localparam logic [4:0] CMD_CALL   = 5'd24;
    localparam logic [4:0] CMD_RET    = 5'd25;
    localparam logic [4:0] CMD_BRANCH = 5'd26;
    localparam logic [4:0] CMD_JUMP   = 5'd27;
    localparam logic [4:0] CMD_HALT   = 5'd28;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ADDR  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef enum logic [3:0] {
        OP_NOP, OP_CONST, OP_NEG, OP_FRAME, OP_POP, OP_LOAD, OP_STORE,
        OP_PUSH, OP_CALL, OP_RET, OP_BRANCH, OP_HALT
    } t_op;

    typedef enum logic [3:0] {
        CK_ADD, CK_SUB, CK_REVSUB, CK_MUL, CK_EQ, CK_NE, CK_LT, CK_LE, CK_GT, CK_GE
    } t_ck;

    typedef struct packed {
        logic [4:0]         cmd;
        logic signed [63:0] imm_value;
        logic [9:0]         slot_offset;
        logic [9:0]         arg_count;
        logic [10:0]        callee_frame_size;
    } t_cmd_item;

    typedef struct packed {
        logic signed [63:0] acc_value;
        logic               branch_taken;
        logic               halted;
        logic [1:0]         status;
    } t_result;

    // Decoded item handed from front to back.
    typedef struct packed {
        t_op         op;
        t_ck         ck;
        logic [63:0] imm;
        logic [9:0]  off;
        logic [9:0]  nargs;
        logic [10:0] fsize;
    } t_dec;

endpackage

@@ hdl/accumulator_frame_stack_unit.sv @@
// Top level of the accumulator frame/stack unit: front decoder queue plus back executor.
// Depends on afsu_pkg, afsu_front, afsu_back (which uses afsu_ram).
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+--------------------
//  command  | in        | push / full           | i_cmd_item (t_cmd_item)
//  result   | out       | pop / empty           | o_result   (t_result)
//
// Each item is issued in the back end with the frame/return-stack RAM read, then
// combined and written back; multiplies add a further state that sums the
// 32-bit partial products. The combine step uses the registered RAM read data.
// Reset (synchronous, active low) clears accumulator, pointers, depth, halt and queues;
// no memory clearing pass is needed. The 2-entry command queue and 2-entry result
// queue let either side stall without holding up the other.
module accumulator_frame_stack_unit
    import afsu_pkg::*;
#(
    parameter int FRAME_WORDS = 1024,
    parameter int CALL_DEPTH  = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_cmd_item i_cmd_item,
    output logic      empty,
    input  logic      pop,
    output t_result   o_result
);
    logic q_valid, q_take;
    t_dec q_item;

    // decode and hold incoming transfers
    afsu_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_item(i_cmd_item), .o_full(full),
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_take(q_take)
    );

    // execute and queue results
    afsu_back #(.FRAME_WORDS(FRAME_WORDS), .CALL_DEPTH(CALL_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_take(q_take),
        .o_empty(empty), .i_pop(pop), .o_result(o_result)
    );
endmodule

@@ hdl/afsu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module afsu_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/afsu_front.sv @@
// Front end: accepts command items, decodes them and queues them for the back end.
// Depends on afsu_pkg.
module afsu_front
    import afsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd_item i_item,
    output logic      o_full,
    output logic      o_q_valid,
    output t_dec      o_q_item,
    input  logic      i_q_take
);
    t_dec       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_dec       dec;
    logic       acc_in;

    always_comb begin
        dec       = '0;
        dec.op    = OP_NOP;
        dec.ck    = CK_ADD;
        dec.imm   = i_item.imm_value;
        dec.off   = i_item.slot_offset;
        dec.nargs = i_item.arg_count;
        dec.fsize = i_item.callee_frame_size;
        case (i_item.cmd) inside
            CMD_CONST:           dec.op = OP_CONST;
            CMD_NEG:             dec.op = OP_NEG;
            [CMD_ADD:CMD_MUL],
            [CMD_EQ:CMD_GE]:     dec.op = OP_FRAME;
            [CMD_PADD:CMD_PGE]:  dec.op = OP_POP;
            CMD_LOAD:            dec.op = OP_LOAD;
            CMD_STORE:           dec.op = OP_STORE;
            CMD_PUSH:            dec.op = OP_PUSH;
            CMD_CALL:            dec.op = OP_CALL;
            CMD_RET:             dec.op = OP_RET;
            CMD_BRANCH:          dec.op = OP_BRANCH;
            CMD_HALT:            dec.op = OP_HALT;
            default:             dec.op = OP_NOP;
        endcase
        case (i_item.cmd)
            CMD_SUB, CMD_PSUB:   dec.ck = CK_SUB;
            CMD_REVSUB:          dec.ck = CK_REVSUB;
            CMD_MUL, CMD_PMUL:   dec.ck = CK_MUL;
            CMD_EQ, CMD_PEQ:     dec.ck = CK_EQ;
            CMD_NE, CMD_PNE:     dec.ck = CK_NE;
            CMD_LT, CMD_PLT:     dec.ck = CK_LT;
            CMD_LE, CMD_PLE:     dec.ck = CK_LE;
            CMD_GT, CMD_PGT:     dec.ck = CK_GT;
            CMD_GE, CMD_PGE:     dec.ck = CK_GE;
            default:             dec.ck = CK_ADD;
        endcase
    end

    assign o_full    = (r_cnt == 2'd2);
    assign acc_in    = i_push && !o_full;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc_in) begin
                r_q[r_wp] <= dec;
                r_wp      <= ~r_wp;
            end
            if (i_q_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(acc_in) - 2'(i_q_take);
        end
    end
endmodule

@@ hdl/afsu_back.sv @@
// Back end: executes decoded items against accumulator, frame RAM and return stack.
// Depends on afsu_pkg and afsu_ram.
module afsu_back
    import afsu_pkg::*;
#(
    parameter int FRAME_WORDS = 1024,
    parameter int CALL_DEPTH  = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_dec    i_q_item,
    output logic    o_q_take,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);
    localparam int AW  = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
    localparam int TW  = $clog2(FRAME_WORDS + 1);
    localparam int WA  = ((AW > 10) ? AW : 10) + 1;
    localparam int CW  = ((TW > 11) ? TW : 11) + 1;
    localparam int RAW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
    localparam int DW  = $clog2(CALL_DEPTH + 1);
    localparam int RSW = AW + TW;

    typedef enum logic [1:0] {S_IDLE, S_DATA, S_MUL} t_state;

    t_state         r_state;
    logic [63:0]    r_acc;
    logic [AW-1:0]  r_base;
    logic [TW-1:0]  r_top;
    logic [DW-1:0]  r_depth;
    logic           r_halt;
    t_op            r_op;
    t_ck            r_ck;
    logic [1:0]     r_status;
    logic           r_taken;
    logic [63:0]    r_p0;
    logic [31:0]    r_p1, r_p2;
    t_result        r_ofifo [2];
    logic           r_owp, r_orp;
    logic [1:0]     r_ocnt;

    // issue-stage signals
    logic           take;
    t_op            n_op;
    logic [1:0]     n_status;
    logic           n_taken;
    logic [63:0]    n_acc;
    logic [AW-1:0]  n_base;
    logic [TW-1:0]  n_top;
    logic [DW-1:0]  n_depth;
    logic           n_halt;
    logic [WA-1:0]  fsum;
    logic [CW-1:0]  nb, nb_end;
    logic           fr_we, rs_we;
    logic [AW-1:0]  fr_waddr, fr_raddr;
    logic [RAW-1:0] rs_waddr, rs_raddr;
    logic [63:0]    fr_rdata;
    logic [RSW-1:0] rs_rdata;
    // finish-stage signals
    logic [63:0]    acc_fin;
    logic           mul_go, fin, opop;
    logic [63:0]    cmb;
    logic [AW-1:0]  ret_base;
    logic [TW-1:0]  ret_top;

    assign take     = (r_state == S_IDLE) && i_q_valid && (r_ocnt != 2'd2);
    assign o_q_take = take;
    assign fsum     = WA'(r_base) + WA'(i_q_item.off);
    assign nb       = CW'(r_top) - CW'(i_q_item.nargs);
    assign nb_end   = nb + CW'(i_q_item.fsize);
    assign rs_waddr = r_depth[RAW-1:0];
    assign rs_raddr = RAW'(r_depth - DW'(1));

    always_comb begin
        n_op     = r_halt ? OP_NOP : i_q_item.op;
        n_status = ST_OK;
        n_taken  = 1'b0;
        n_acc    = r_acc;
        n_base   = r_base;
        n_top    = r_top;
        n_depth  = r_depth;
        n_halt   = r_halt;
        fr_we    = 1'b0;
        rs_we    = 1'b0;
        fr_waddr = fsum[AW-1:0];
        fr_raddr = fsum[AW-1:0];
        case (n_op)
            OP_CONST:  n_acc = i_q_item.imm;
            OP_NEG:    n_acc = 64'd0 - r_acc;
            OP_FRAME, OP_LOAD: begin
                if (fsum >= WA'(FRAME_WORDS)) n_status = ST_ADDR;
            end
            OP_STORE: begin
                if (fsum >= WA'(FRAME_WORDS)) n_status = ST_ADDR;
                else fr_we = 1'b1;
            end
            OP_POP: begin
                fr_raddr = AW'(r_top - TW'(1));
                if (r_top == '0 || r_top > TW'(FRAME_WORDS)) n_status = ST_ADDR;
                else n_top = r_top - TW'(1);
            end
            OP_PUSH: begin
                fr_waddr = r_top[AW-1:0];
                if (r_top >= TW'(FRAME_WORDS)) n_status = ST_ADDR;
                else begin
                    fr_we = 1'b1;
                    n_top = r_top + TW'(1);
                end
            end
            OP_CALL: begin
                if (r_depth >= DW'(CALL_DEPTH)) n_status = ST_FULL;
                else if (CW'(i_q_item.nargs) > CW'(r_top)) n_status = ST_ADDR;
                else if (nb >= CW'(FRAME_WORDS) || nb_end > CW'(FRAME_WORDS))
                    n_status = ST_ADDR;
                else begin
                    rs_we   = 1'b1;
                    n_depth = r_depth + DW'(1);
                    n_base  = nb[AW-1:0];
                    n_top   = nb_end[TW-1:0];
                end
            end
            OP_RET: begin
                if (r_depth == '0 || r_depth > DW'(CALL_DEPTH)) n_status = ST_EMPTY;
                else n_depth = r_depth - DW'(1);
            end
            OP_BRANCH: n_taken = (r_acc != 64'd0);
            OP_HALT:   n_halt = 1'b1;
            default:   ;
        endcase
        fr_we = fr_we && take;
        rs_we = rs_we && take;
    end

    afsu_ram #(.WIDTH(64), .DEPTH(FRAME_WORDS)) u_frame (
        .i_clk(i_clk), .i_we(fr_we), .i_waddr(fr_waddr), .i_wdata(r_acc),
        .i_raddr(fr_raddr), .o_rdata(fr_rdata)
    );

    // save caller base and the new base, which return restores as the stack top
    afsu_ram #(.WIDTH(RSW), .DEPTH(CALL_DEPTH)) u_rstack (
        .i_clk(i_clk), .i_we(rs_we), .i_waddr(rs_waddr), .i_wdata({r_base, nb[TW-1:0]}),
        .i_raddr(rs_raddr), .o_rdata(rs_rdata)
    );

    assign ret_base = rs_rdata[RSW-1:TW];
    assign ret_top  = rs_rdata[TW-1:0];

    always_comb begin
        case (r_ck)
            CK_ADD:    cmb = fr_rdata + r_acc;
            CK_SUB:    cmb = fr_rdata - r_acc;
            CK_REVSUB: cmb = r_acc - fr_rdata;
            CK_EQ:     cmb = 64'(fr_rdata == r_acc);
            CK_NE:     cmb = 64'(fr_rdata != r_acc);
            CK_LT:     cmb = 64'($signed(fr_rdata) <  $signed(r_acc));
            CK_LE:     cmb = 64'($signed(fr_rdata) <= $signed(r_acc));
            CK_GT:     cmb = 64'($signed(fr_rdata) >  $signed(r_acc));
            CK_GE:     cmb = 64'($signed(fr_rdata) >= $signed(r_acc));
            default:   cmb = r_acc;
        endcase
        acc_fin = r_acc;
        mul_go  = 1'b0;
        if (r_state == S_DATA && r_status == ST_OK) begin
            case (r_op)
                OP_FRAME, OP_POP: begin
                    if (r_ck == CK_MUL) mul_go = 1'b1;
                    else acc_fin = cmb;
                end
                OP_LOAD: acc_fin = fr_rdata;
                default: ;
            endcase
        end
        if (r_state == S_MUL) acc_fin = r_p0 + {r_p1 + r_p2, 32'd0};
        fin = (r_state == S_DATA && !mul_go) || (r_state == S_MUL);
    end

    assign o_empty  = (r_ocnt == 2'd0);
    assign o_result = r_ofifo[r_orp];
    assign opop     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_base  <= '0;
            r_top   <= '0;
            r_depth <= '0;
            r_halt  <= 1'b0;
            r_owp   <= 1'b0;
            r_orp   <= 1'b0;
            r_ocnt  <= 2'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_op     <= n_op;
                        r_ck     <= i_q_item.ck;
                        r_status <= n_status;
                        r_taken  <= n_taken;
                        r_acc    <= n_acc;
                        r_base   <= n_base;
                        r_top    <= n_top;
                        r_depth  <= n_depth;
                        r_halt   <= n_halt;
                        r_state  <= S_DATA;
                    end
                end
                S_DATA: begin
                    r_p0    <= 64'(fr_rdata[31:0] * r_acc[31:0]);
                    r_p1    <= 32'(fr_rdata[31:0] * r_acc[63:32]);
                    r_p2    <= 32'(fr_rdata[63:32] * r_acc[31:0]);
                    r_acc   <= acc_fin;
                    r_state <= mul_go ? S_MUL : S_IDLE;
                    if (r_op == OP_RET && r_status == ST_OK) begin
                        r_base <= ret_base;
                        r_top  <= ret_top;
                    end
                end
                S_MUL: begin
                    r_acc   <= acc_fin;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (fin) begin
                r_ofifo[r_owp] <= '{acc_value: acc_fin, branch_taken: r_taken,
                                    halted: r_halt, status: r_status};
                r_owp <= ~r_owp;
            end
            if (opop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + 2'(fin) - 2'(opop);
        end
    end

`ifndef SYNTHESIS
    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt != 2'd3) else $error("result queue overrun");
    a_fin_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |-> (r_ocnt != 2'd2) || opop) else $error("finish into full result queue");
    a_mul_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |-> $past(r_state) == S_DATA) else $error("bad mul sequence");
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(CALL_DEPTH)) else $error("return depth beyond bound");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_halt) && $past(i_rst_n) |-> r_halt) else $error("halt cleared");
`endif
endmodule
